>>> hw/rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types, codes and helpers for the frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_PAY  = 3'd4
  } phase_t;

  localparam logic [2:0] KIND_TEXT       = 3'd0;
  localparam logic [2:0] KIND_TEXT_PART  = 3'd1;
  localparam logic [2:0] KIND_BIN        = 3'd2;
  localparam logic [2:0] KIND_BIN_PART   = 3'd3;
  localparam logic [2:0] KIND_PING       = 3'd4;
  localparam logic [2:0] KIND_PONG       = 3'd5;
  localparam logic [2:0] KIND_ERROR      = 3'd6;
  localparam logic [2:0] KIND_BAD        = 3'd7;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_MASK   = 2'd1;
  localparam logic [1:0] ERR_LENGTH = 2'd2;
  localparam logic [1:0] ERR_OPCODE = 2'd3;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] LEN7_MAX_SHORT = 7'd125;
  localparam logic [6:0] LEN7_EXT16     = 7'd126;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  localparam logic CFG_EXPECT_MASKED = 1'b0;
  localparam logic CFG_MAX_PAYLOAD   = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic [2:0] frame_kind;
    logic [1:0] error_code;
    logic       last_of_frame;
    logic       pong_request;
  } res_t;

  function automatic logic [2:0] kind_of_frame(input logic [7:0] hdr0);
    logic [2:0] k;
    unique case (hdr0[3:0])
      OP_CONT, OP_TEXT: k = hdr0[7] ? KIND_TEXT : KIND_TEXT_PART;
      OP_BIN:           k = hdr0[7] ? KIND_BIN : KIND_BIN_PART;
      OP_PING:          k = KIND_PING;
      OP_PONG:          k = KIND_PONG;
      default:          k = KIND_BAD;
    endcase
    return k;
  endfunction

endpackage

>>> hw/rtl/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser
// Byte-wide header parser and payload unmasker; one byte per cycle on byte_en.
// ----------------------------------------------------------------------------
module wsd_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_en,
  input  logic [7:0]       in_byte,
  input  logic             expect_masked,
  input  logic [31:0]      max_payload,
  output logic             res_valid,
  output wsd_pkg::res_t    res
);

  wsd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  hdr0_r, hdr0_nxt;
  logic        mask_r, mask_nxt;
  logic [3:0]  left_r, left_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] key_r, key_nxt;
  logic [31:0] idx_r, idx_nxt;
  logic        halted_r, halted_nxt;

  logic        ld_go, st_go, fail_go;
  logic [31:0] ld_len, st_len;
  logic [1:0]  fail_code;
  logic [2:0]  kind;
  logic [31:0] idx_inc;
  logic [7:0]  key_byte;
  logic        pay_last;

  assign kind    = wsd_pkg::kind_of_frame(hdr0_r);
  assign idx_inc = idx_r + 32'd1;

  always_comb begin
    case (idx_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    hdr0_nxt   = hdr0_r;
    mask_nxt   = mask_r;
    left_nxt   = left_r;
    len_nxt    = len_r;
    key_nxt    = key_r;
    idx_nxt    = idx_r;
    halted_nxt = halted_r;
    ld_go      = 1'b0;
    ld_len     = len_r;
    st_go      = 1'b0;
    st_len     = len_r;
    fail_go    = 1'b0;
    fail_code  = wsd_pkg::ERR_NONE;
    pay_last   = 1'b0;
    res_valid  = 1'b0;
    res        = '0;

    if (byte_en && !halted_r) begin
      unique case (phase_r)
        wsd_pkg::PH_HDR0: begin
          hdr0_nxt  = in_byte;
          phase_nxt = wsd_pkg::PH_HDR1;
        end
        wsd_pkg::PH_HDR1: begin
          mask_nxt = in_byte[7];
          if (in_byte[7] != expect_masked) begin
            fail_go   = 1'b1;
            fail_code = wsd_pkg::ERR_MASK;
          end else if (in_byte[6:0] <= wsd_pkg::LEN7_MAX_SHORT) begin
            ld_go  = 1'b1;
            ld_len = {25'd0, in_byte[6:0]};
          end else begin
            len_nxt   = '0;
            left_nxt  = (in_byte[6:0] == wsd_pkg::LEN7_EXT16) ?
                        wsd_pkg::EXT16_BYTES : wsd_pkg::EXT64_BYTES;
            phase_nxt = wsd_pkg::PH_EXT;
          end
        end
        wsd_pkg::PH_EXT: begin
          len_nxt  = {len_r[23:0], in_byte};
          left_nxt = left_r - 4'd1;
          if (left_r == 4'd1) begin
            ld_go  = 1'b1;
            ld_len = {len_r[23:0], in_byte};
          end
        end
        wsd_pkg::PH_KEY: begin
          key_nxt  = {key_r[23:0], in_byte};
          left_nxt = left_r - 4'd1;
          if (left_r == 4'd1) begin
            st_go = 1'b1;
          end
        end
        wsd_pkg::PH_PAY: begin
          pay_last = (idx_inc == len_r);
          idx_nxt  = idx_inc;
          if (pay_last) begin
            phase_nxt = wsd_pkg::PH_HDR0;
          end
          if (kind <= wsd_pkg::KIND_BIN_PART) begin
            res_valid         = 1'b1;
            res.data_byte     = in_byte ^ key_byte;
            res.data_valid    = 1'b1;
            res.frame_kind    = kind;
            res.last_of_frame = pay_last;
          end else if (pay_last) begin
            res_valid         = 1'b1;
            res.frame_kind    = kind;
            res.last_of_frame = 1'b1;
            res.pong_request  = (kind == wsd_pkg::KIND_PING);
          end
        end
        default: begin
          phase_nxt = wsd_pkg::PH_HDR0;
        end
      endcase
    end

    // length complete: checks, then key, payload or (zero length) next header
    if (ld_go) begin
      len_nxt = ld_len;
      if (expect_masked && (ld_len > max_payload)) begin
        fail_go   = 1'b1;
        fail_code = wsd_pkg::ERR_LENGTH;
      end else if (kind == wsd_pkg::KIND_BAD) begin
        fail_go   = 1'b1;
        fail_code = wsd_pkg::ERR_OPCODE;
      end else begin
        key_nxt = '0;
        if (mask_nxt) begin
          phase_nxt = wsd_pkg::PH_KEY;
          left_nxt  = wsd_pkg::KEY_BYTES;
        end else begin
          st_go  = 1'b1;
          st_len = ld_len;
        end
      end
    end

    // header complete
    if (st_go) begin
      idx_nxt = '0;
      if (st_len == 32'd0) begin
        phase_nxt         = wsd_pkg::PH_HDR0;
        res_valid         = 1'b1;
        res.frame_kind    = kind;
        res.last_of_frame = 1'b1;
        res.pong_request  = (kind == wsd_pkg::KIND_PING);
      end else begin
        phase_nxt = wsd_pkg::PH_PAY;
      end
    end

    if (fail_go) begin
      halted_nxt        = 1'b1;
      phase_nxt         = wsd_pkg::PH_HDR0;
      res_valid         = 1'b1;
      res               = '0;
      res.frame_kind    = wsd_pkg::KIND_ERROR;
      res.error_code    = fail_code;
      res.last_of_frame = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= wsd_pkg::PH_HDR0;
      hdr0_r   <= '0;
      mask_r   <= 1'b0;
      left_r   <= '0;
      len_r    <= '0;
      key_r    <= '0;
      idx_r    <= '0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      hdr0_r   <= hdr0_nxt;
      mask_r   <= mask_nxt;
      left_r   <= left_nxt;
      len_r    <= len_nxt;
      key_r    <= key_nxt;
      idx_r    <= idx_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

>>> hw/rtl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Each result is registered in the output buffer before it shows on out_valid.
// Throughput: one byte per cycle unless in_stall; parser updates per byte.
// A two-entry output buffer (result register plus skid) takes one more result
// while the output stalls; in_stall rises only when both are full.
// Reset (rst_n low, synchronous) clears the parser, the buffer and the error
// halt, and loads expect_masked = 1, max_payload = 65536.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data_byte,
  output logic        out_data_valid,
  output logic [2:0]  out_frame_kind,
  output logic [1:0]  out_error_code,
  output logic        out_last_of_frame,
  output logic        out_pong_request,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic          expect_masked_r;
  logic [31:0]   max_payload_r;
  logic          byte_en;
  logic          res_valid;
  wsd_pkg::res_t res;
  wsd_pkg::res_t main_r, skid_r;
  logic          main_valid_r, skid_valid_r;
  logic          pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_masked_r <= 1'b1;
      max_payload_r   <= 32'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wsd_pkg::CFG_EXPECT_MASKED: expect_masked_r <= cfg_data[0];
        wsd_pkg::CFG_MAX_PAYLOAD:   max_payload_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = skid_valid_r;
  assign byte_en  = in_valid && !in_stall;

  wsd_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_en       (byte_en),
    .in_byte       (in_byte),
    .expect_masked (expect_masked_r),
    .max_payload   (max_payload_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  assign pop = main_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!main_valid_r || pop) begin
      main_valid_r <= res_valid;
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (!main_valid_r || pop) begin
      if (res_valid) begin
        main_r <= res;
      end
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid         = main_valid_r;
  assign out_data_byte     = main_r.data_byte;
  assign out_data_valid    = main_r.data_valid;
  assign out_frame_kind    = main_r.frame_kind;
  assign out_error_code    = main_r.error_code;
  assign out_last_of_frame = main_r.last_of_frame;
  assign out_pong_request  = main_r.pong_request;

endmodule
